### hdl/eow_pkg.sv
package eow_pkg;

    localparam int COORD_W    = 26;
    localparam int ANGLE_W    = 16;
    localparam int CFG_W      = 20;
    localparam int IN_DATA_W  = 200;
    localparam int OUT_DATA_W = 128;

    localparam int CORDIC_STEPS = 15;
    localparam int SQRT_STEPS   = 27;
    localparam int DIV_STEPS    = 30;
    localparam int MUL_STEPS    = 8;

    localparam logic [1:0] OP_CLEAR    = 2'd0;
    localparam logic [1:0] OP_APPEND   = 2'd1;
    localparam logic [1:0] OP_WAYPOINT = 2'd2;

    localparam logic [1:0] REG_OFFSET_DISTANCE    = 2'd0;
    localparam logic [1:0] REG_MAX_EDGE_DISTANCE  = 2'd1;
    localparam logic [1:0] REG_MIN_SEGMENT_LENGTH = 2'd2;

    localparam logic [15:0] QUARTER_TURN  = 16'd16384;
    localparam logic [15:0] THREE_QUARTER = 16'd49152;
    localparam logic [15:0] HALF_TURN     = 16'd32768;

    localparam logic [15:0] CORDIC_ATAN [16] = '{
        16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
        16'd41, 16'd20, 16'd10, 16'd5, 16'd3, 16'd1, 16'd1, 16'd0
    };

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MINSQ,
        ST_MINSQ_LD,
        ST_RD,
        ST_LOAD,
        ST_MUL,
        ST_TEST,
        ST_CORDIC,
        ST_SIDE,
        ST_SQRT,
        ST_ROOT,
        ST_DIV_LD,
        ST_DIV,
        ST_DIV_END,
        ST_NEXT,
        ST_FMUL_X,
        ST_FMUL_Y,
        ST_FOUT
    } state_t;

    typedef enum logic [1:0] {
        DIV_GAP,
        DIV_DX,
        DIV_DY
    } div_use_t;

    function automatic logic [25:0] sat26(input logic signed [31:0] v);
        logic [25:0] r;
        if (v > 32'sd33554431) begin
            r = 26'h1FFFFFF;
        end else if (v < -32'sd33554432) begin
            r = 26'h2000000;
        end else begin
            r = v[25:0];
        end
        return r;
    endfunction

endpackage

### hdl/edge_offset_waypoint.sv
// Channel  | Dir | Beat contents
// s_       | in  | tuser: opcode; tdata: start x/y, end x/y, point x/y/height, heading
// m_       | out | tdata: out x/y/height, heading, edge gap, edge index
// apb      | cfg | offset_distance, max_edge_distance, min_segment_length at 0, 4, 8
//
// Clear and append beats are taken in the idle state. A waypoint scans the N stored
// segments; a segment rejected by the length or foot test skips the square root and the
// gap divide, and once a segment is found the final shift runs the divider twice.
// The divider is a 30-step and the square root a 27-step iterative unit.
// Reset is synchronous; it empties the table and loads the register defaults.
// A finished result waits in the output register while the next beat is taken.
module edge_offset_waypoint #(
    parameter int MAX_SEGMENTS    = 256,
    parameter int COORD_FRAC_BITS = 10
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_x, start_y, end_x, end_y, point_x, point_y, point_height, point_heading
    input  logic [199:0] s_tdata,
    // opcode
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_height, out_heading, edge_gap, edge_index
    output logic [127:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam logic [19:0] OFFSET_RST = 20'(3 << (COORD_FRAC_BITS - 1));
    localparam logic [19:0] MAX_RST    = 20'(8 << COORD_FRAC_BITS);
    localparam logic [19:0] MIN_RST    = 20'(((1 << COORD_FRAC_BITS) + 50) / 100);

    eow_pkg::state_t   state_reg, state_next;
    eow_pkg::div_use_t div_use_reg;

    logic [CNT_W-1:0] seg_count_reg, idx_reg;
    logic [103:0]     seg_mem [MAX_SEGMENTS];
    logic [103:0]     rd_data_reg;

    logic [19:0] offset_reg, max_reg, min_reg;
    logic [39:0] minsq_reg;

    logic signed [25:0] px_reg, py_reg, pz_reg;
    logic [15:0]        head_reg;

    logic signed [26:0] fx_reg, fy_reg, pfx_reg, pfy_reg, plx_reg, ply_reg;
    logic signed [27:0] mul_a, mul_b;
    logic signed [55:0] prod_reg, acc_reg, l2_reg, c_reg, dot1_reg, dot2_reg;
    logic [4:0]         cnt_reg;

    logic signed [41:0] cx_reg, cy_reg, cx_sh, cy_sh, cx_init, cy_init;
    logic [15:0]        cz_reg, ang_reg, dir_diff, atan_val;

    logic [53:0] sq_x_reg;
    logic [54:0] sq_r_reg, sq_b_reg, sq_t;
    logic        sq_ge;
    logic [26:0] len_reg;

    logic [27:0] div_rem_reg, div_t;
    logic [29:0] div_num_reg, div_q_reg;
    logic [26:0] div_d_reg, div_d_src;
    logic [55:0] div_src, div_num_full;
    logic        div_ge, div_neg_reg;

    logic               found_reg, best_cpos_reg, best_cneg_reg;
    logic [19:0]        best_h_reg;
    logic signed [26:0] best_fx_reg, best_fy_reg;
    logic [26:0]        best_len_reg;
    logic [15:0]        best_ang_reg;
    logic [CNT_W-1:0]   best_i_reg;

    logic signed [30:0] dx_reg, dy_reg, q_ext;
    logic signed [20:0] step;
    logic signed [31:0] sum_x, sum_y;

    logic         m_tvalid_reg;
    logic [127:0] m_tdata_reg;

    logic in_accept, cfg_wr, fwd, c_neg, c_pos, skip_test, skip_side;
    logic last_seg, gap_ok, gap_better, s_zero, out_free;
    logic [1:0] opcode;

    logic signed [26:0] rd_sx, rd_sy, rd_ex, rd_ey, p_x, p_y;

    assign opcode    = s_tuser;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_wr    = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        unique case (paddr[3:2])
            eow_pkg::REG_OFFSET_DISTANCE:    prdata = {12'b0, offset_reg};
            eow_pkg::REG_MAX_EDGE_DISTANCE:  prdata = {12'b0, max_reg};
            eow_pkg::REG_MIN_SEGMENT_LENGTH: prdata = {12'b0, min_reg};
            default:                         prdata = 32'b0;
        endcase
    end

    assign rd_sx = {rd_data_reg[25], rd_data_reg[25:0]};
    assign rd_sy = {rd_data_reg[51], rd_data_reg[51:26]};
    assign rd_ex = {rd_data_reg[77], rd_data_reg[77:52]};
    assign rd_ey = {rd_data_reg[103], rd_data_reg[103:78]};
    assign p_x   = {px_reg[25], px_reg};
    assign p_y   = {py_reg[25], py_reg};

    assign c_neg     = c_reg < 56'sd0;
    assign c_pos     = c_reg > 56'sd0;
    assign skip_test = (l2_reg == 56'sd0) || (l2_reg[53:0] < {14'b0, minsq_reg})
                       || (dot1_reg > 56'sd0) || (dot2_reg < 56'sd0);

    assign cx_sh    = cx_reg >>> cnt_reg[3:0];
    assign cy_sh    = cy_reg >>> cnt_reg[3:0];
    assign atan_val = eow_pkg::CORDIC_ATAN[cnt_reg[3:0]];
    assign cx_init  = {{3{fx_reg[26]}}, fx_reg, 12'b0};
    assign cy_init  = {{3{fy_reg[26]}}, fy_reg, 12'b0};
    assign dir_diff = cz_reg - head_reg;
    assign fwd      = (dir_diff < eow_pkg::QUARTER_TURN) || (dir_diff > eow_pkg::THREE_QUARTER);
    assign skip_side = fwd ? c_neg : c_pos;

    assign sq_t  = sq_r_reg + sq_b_reg;
    assign sq_ge = {1'b0, sq_x_reg} >= sq_t;

    assign div_t  = {div_rem_reg[26:0], div_num_reg[29]};
    assign div_ge = div_t >= {1'b0, div_d_reg};
    assign div_d_src = (div_use_reg == eow_pkg::DIV_GAP) ? len_reg : best_len_reg;
    always_comb begin
        if (div_use_reg == eow_pkg::DIV_GAP) begin
            div_src = c_neg ? 56'(-c_reg) : 56'(c_reg);
        end else begin
            div_src = prod_reg[55] ? 56'(-prod_reg) : 56'(prod_reg);
        end
    end
    assign div_num_full = div_src + {30'b0, div_d_src[26:1]};

    assign step       = $signed({1'b0, best_h_reg}) - $signed({1'b0, offset_reg});
    assign gap_ok     = div_q_reg <= {10'b0, max_reg};
    assign gap_better = !found_reg || (div_q_reg[19:0] < best_h_reg);
    assign last_seg   = (idx_reg + CNT_W'(1)) == seg_count_reg;
    assign s_zero     = !(best_cpos_reg || best_cneg_reg);
    assign q_ext      = $signed({1'b0, div_q_reg});
    assign sum_x      = 32'(px_reg) + 32'(dx_reg);
    assign sum_y      = 32'(py_reg) + 32'(dy_reg);

    always_comb begin
        mul_a = 28'sd0;
        mul_b = 28'sd0;
        unique case (state_reg)
            eow_pkg::ST_MUL: begin
                unique case (cnt_reg[2:0])
                    3'd0: begin mul_a = 28'(fx_reg);  mul_b = 28'(fx_reg);  end
                    3'd1: begin mul_a = 28'(fy_reg);  mul_b = 28'(fy_reg);  end
                    3'd2: begin mul_a = 28'(pfx_reg); mul_b = 28'(ply_reg); end
                    3'd3: begin mul_a = 28'(pfy_reg); mul_b = 28'(plx_reg); end
                    3'd4: begin mul_a = 28'(fx_reg);  mul_b = 28'(pfx_reg); end
                    3'd5: begin mul_a = 28'(fy_reg);  mul_b = 28'(pfy_reg); end
                    3'd6: begin mul_a = 28'(fx_reg);  mul_b = 28'(plx_reg); end
                    3'd7: begin mul_a = 28'(fy_reg);  mul_b = 28'(ply_reg); end
                    default: ;
                endcase
            end
            eow_pkg::ST_MINSQ: begin
                mul_a = $signed({8'b0, min_reg});
                mul_b = $signed({8'b0, min_reg});
            end
            eow_pkg::ST_FMUL_X: begin
                mul_a = 28'(best_fy_reg);
                mul_b = 28'(step);
            end
            eow_pkg::ST_FMUL_Y: begin
                mul_a = 28'(best_fx_reg);
                mul_b = 28'(step);
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            eow_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && opcode == eow_pkg::OP_WAYPOINT) begin
                    state_next = eow_pkg::ST_MINSQ;
                end
            end
            eow_pkg::ST_MINSQ:    state_next = eow_pkg::ST_MINSQ_LD;
            eow_pkg::ST_MINSQ_LD: begin
                state_next = (seg_count_reg == '0) ? eow_pkg::ST_IDLE : eow_pkg::ST_RD;
            end
            eow_pkg::ST_RD:       state_next = eow_pkg::ST_LOAD;
            eow_pkg::ST_LOAD:     state_next = eow_pkg::ST_MUL;
            eow_pkg::ST_MUL: begin
                if (cnt_reg == 5'(eow_pkg::MUL_STEPS)) begin
                    state_next = eow_pkg::ST_TEST;
                end
            end
            eow_pkg::ST_TEST: begin
                state_next = skip_test ? eow_pkg::ST_NEXT : eow_pkg::ST_CORDIC;
            end
            eow_pkg::ST_CORDIC: begin
                if (cnt_reg == 5'(eow_pkg::CORDIC_STEPS - 1)) begin
                    state_next = eow_pkg::ST_SIDE;
                end
            end
            eow_pkg::ST_SIDE: begin
                state_next = skip_side ? eow_pkg::ST_NEXT : eow_pkg::ST_SQRT;
            end
            eow_pkg::ST_SQRT: begin
                if (cnt_reg == 5'(eow_pkg::SQRT_STEPS - 1)) begin
                    state_next = eow_pkg::ST_ROOT;
                end
            end
            eow_pkg::ST_ROOT:   state_next = eow_pkg::ST_DIV_LD;
            eow_pkg::ST_DIV_LD: state_next = eow_pkg::ST_DIV;
            eow_pkg::ST_DIV: begin
                if (cnt_reg == 5'(eow_pkg::DIV_STEPS - 1)) begin
                    state_next = eow_pkg::ST_DIV_END;
                end
            end
            eow_pkg::ST_DIV_END: begin
                unique case (div_use_reg)
                    eow_pkg::DIV_GAP: state_next = eow_pkg::ST_NEXT;
                    eow_pkg::DIV_DX:  state_next = eow_pkg::ST_FMUL_Y;
                    eow_pkg::DIV_DY:  state_next = eow_pkg::ST_FOUT;
                    default:          state_next = eow_pkg::ST_IDLE;
                endcase
            end
            eow_pkg::ST_NEXT: begin
                if (!last_seg) begin
                    state_next = eow_pkg::ST_RD;
                end else if (found_reg) begin
                    state_next = eow_pkg::ST_FMUL_X;
                end else begin
                    state_next = eow_pkg::ST_IDLE;
                end
            end
            eow_pkg::ST_FMUL_X: state_next = eow_pkg::ST_DIV_LD;
            eow_pkg::ST_FMUL_Y: state_next = eow_pkg::ST_DIV_LD;
            eow_pkg::ST_FOUT: begin
                if (out_free) begin
                    state_next = eow_pkg::ST_IDLE;
                end
            end
            default: state_next = eow_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= eow_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_count_reg <= '0;
            offset_reg    <= OFFSET_RST;
            max_reg       <= MAX_RST;
            min_reg       <= MIN_RST;
            m_tvalid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            div_use_reg   <= eow_pkg::DIV_GAP;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[3:2])
                    eow_pkg::REG_OFFSET_DISTANCE:    offset_reg <= pwdata[19:0];
                    eow_pkg::REG_MAX_EDGE_DISTANCE:  max_reg    <= pwdata[19:0];
                    eow_pkg::REG_MIN_SEGMENT_LENGTH: min_reg    <= pwdata[19:0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                if (opcode == eow_pkg::OP_CLEAR) begin
                    seg_count_reg <= '0;
                end else if (opcode == eow_pkg::OP_APPEND &&
                             seg_count_reg < CNT_W'(MAX_SEGMENTS)) begin
                    seg_count_reg <= seg_count_reg + CNT_W'(1);
                end
                found_reg <= 1'b0;
            end
            if (state_reg == eow_pkg::ST_FOUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                eow_pkg::ST_MINSQ_LD: idx_reg <= '0;
                eow_pkg::ST_NEXT:     idx_reg <= idx_reg + CNT_W'(1);
                eow_pkg::ST_ROOT:     div_use_reg <= eow_pkg::DIV_GAP;
                eow_pkg::ST_FMUL_X:   div_use_reg <= eow_pkg::DIV_DX;
                eow_pkg::ST_FMUL_Y:   div_use_reg <= eow_pkg::DIV_DY;
                eow_pkg::ST_DIV_END: begin
                    if (div_use_reg == eow_pkg::DIV_GAP && gap_ok && gap_better) begin
                        found_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
            if (state_reg != state_next) begin
                cnt_reg <= '0;
            end else begin
                cnt_reg <= cnt_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && opcode == eow_pkg::OP_APPEND &&
            seg_count_reg < CNT_W'(MAX_SEGMENTS)) begin
            seg_mem[seg_count_reg[IDX_W-1:0]] <= s_tdata[103:0];
        end
        if (state_reg == eow_pkg::ST_RD) begin
            rd_data_reg <= seg_mem[idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (in_accept) begin
            px_reg   <= s_tdata[129:104];
            py_reg   <= s_tdata[155:130];
            pz_reg   <= s_tdata[181:156];
            head_reg <= s_tdata[197:182];
        end
        unique case (state_reg)
            eow_pkg::ST_MINSQ_LD: minsq_reg <= prod_reg[39:0];
            eow_pkg::ST_LOAD: begin
                fx_reg  <= rd_ex - rd_sx;
                fy_reg  <= rd_ey - rd_sy;
                pfx_reg <= rd_sx - p_x;
                pfy_reg <= rd_sy - p_y;
                plx_reg <= rd_ex - p_x;
                ply_reg <= rd_ey - p_y;
            end
            eow_pkg::ST_MUL: begin
                if (cnt_reg != 5'd0) begin
                    unique case (cnt_reg[2:0])
                        3'd1, 3'd3, 3'd5, 3'd7: acc_reg <= prod_reg;
                        3'd2: l2_reg   <= acc_reg + prod_reg;
                        3'd4: c_reg    <= acc_reg - prod_reg;
                        3'd6: l2_reg   <= l2_reg;
                        3'd0: dot2_reg <= acc_reg + prod_reg;
                        default: ;
                    endcase
                    if (cnt_reg[2:0] == 3'd6) begin
                        dot1_reg <= acc_reg + prod_reg;
                    end
                end
            end
            eow_pkg::ST_TEST: begin
                cx_reg <= fx_reg[26] ? -cx_init : cx_init;
                cy_reg <= fx_reg[26] ? -cy_init : cy_init;
                cz_reg <= fx_reg[26] ? eow_pkg::HALF_TURN : 16'd0;
            end
            eow_pkg::ST_CORDIC: begin
                if (!cy_reg[41]) begin
                    cx_reg <= cx_reg + cy_sh;
                    cy_reg <= cy_reg - cx_sh;
                    cz_reg <= cz_reg + atan_val;
                end else begin
                    cx_reg <= cx_reg - cy_sh;
                    cy_reg <= cy_reg + cx_sh;
                    cz_reg <= cz_reg - atan_val;
                end
            end
            eow_pkg::ST_SIDE: begin
                ang_reg  <= fwd ? cz_reg : cz_reg + eow_pkg::HALF_TURN;
                sq_x_reg <= l2_reg[53:0];
                sq_r_reg <= '0;
                sq_b_reg <= 55'd1 << 52;
            end
            eow_pkg::ST_SQRT: begin
                if (sq_ge) begin
                    sq_x_reg <= 54'({1'b0, sq_x_reg} - sq_t);
                    sq_r_reg <= (sq_r_reg >> 1) + sq_b_reg;
                end else begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_b_reg <= sq_b_reg >> 2;
            end
            eow_pkg::ST_ROOT: begin
                len_reg <= sq_r_reg[26:0] + 27'({1'b0, sq_x_reg} > sq_r_reg);
            end
            eow_pkg::ST_DIV_LD: begin
                div_rem_reg <= {2'b0, div_num_full[55:30]};
                div_num_reg <= div_num_full[29:0];
                div_q_reg   <= '0;
                div_d_reg   <= div_d_src;
                div_neg_reg <= best_cneg_reg ^ prod_reg[55];
            end
            eow_pkg::ST_DIV: begin
                div_rem_reg <= div_ge ? div_t - {1'b0, div_d_reg} : div_t;
                div_num_reg <= {div_num_reg[28:0], 1'b0};
                div_q_reg   <= {div_q_reg[28:0], div_ge};
            end
            eow_pkg::ST_DIV_END: begin
                unique case (div_use_reg)
                    eow_pkg::DIV_GAP: begin
                        if (gap_ok && gap_better) begin
                            best_h_reg    <= div_q_reg[19:0];
                            best_cpos_reg <= c_pos;
                            best_cneg_reg <= c_neg;
                            best_fx_reg   <= fx_reg;
                            best_fy_reg   <= fy_reg;
                            best_len_reg  <= len_reg;
                            best_ang_reg  <= ang_reg;
                            best_i_reg    <= idx_reg;
                        end
                    end
                    eow_pkg::DIV_DX: begin
                        dx_reg <= s_zero ? 31'sd0 : (div_neg_reg ? -q_ext : q_ext);
                    end
                    eow_pkg::DIV_DY: begin
                        dy_reg <= s_zero ? 31'sd0 : (div_neg_reg ? q_ext : -q_ext);
                    end
                    default: ;
                endcase
            end
            eow_pkg::ST_FOUT: begin
                if (out_free) begin
                    m_tdata_reg <= {6'b0, 8'(best_i_reg), best_h_reg, best_ang_reg, pz_reg,
                                    eow_pkg::sat26(sum_y), eow_pkg::sat26(sum_x)};
                end
            end
            default: ;
        endcase
    end

    a_busy_after_waypoint: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == eow_pkg::OP_WAYPOINT) |=> !s_tready)
        else $error("waypoint beat did not start a table scan");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == eow_pkg::ST_RD) |-> (idx_reg < seg_count_reg))
        else $error("table read beyond the stored segments");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        seg_count_reg <= CNT_W'(MAX_SEGMENTS))
        else $error("segment count exceeds table depth");

    a_best_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == eow_pkg::ST_FOUT) |-> (found_reg && best_h_reg <= max_reg))
        else $error("result issued without a segment inside the distance limit");

endmodule
